// ===== design/wca_pkg.sv =====
`timescale 1ns / 1ps

package wca_pkg;

  // Depth of the coverage store.
  localparam int unsigned MAX_LEN = 1048576;
  localparam int unsigned ADDR_W = $clog2(MAX_LEN);
  // Wide enough to hold the effective limit, which may equal MAX_LEN itself.
  localparam int unsigned LIM_W = $clog2(MAX_LEN + 1);

  localparam int unsigned CHROM_RESET = 1048576;
  localparam int unsigned LIM_RESET = (CHROM_RESET < MAX_LEN) ? CHROM_RESET : MAX_LEN;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LIM_W-1:0] lim_t;
  typedef logic [31:0] cov_t;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_CIGAR = 2'd1,
    OP_SCAN  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [3:0] CIGAR_MATCH = 4'd0;
  localparam logic [3:0] CIGAR_INS   = 4'd1;
  localparam logic [3:0] CIGAR_SKIP  = 4'd3;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CODE  = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  localparam logic KIND_COV = 1'b0;
  localparam logic KIND_ERR = 1'b1;

  // Request to the coverage store for one cycle.
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    cov_t  wr_data;
  } ram_req_t;

endpackage

// ===== design/wca_in_if.sv =====
`timescale 1ns / 1ps

interface wca_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [19:0] position;
  logic [15:0] weight;
  logic [3:0]  cigar_code;
  logic [27:0] cigar_length;

  modport source (
    output valid, operation, position, weight, cigar_code, cigar_length,
    input  ready
  );
  modport sink (
    input  valid, operation, position, weight, cigar_code, cigar_length,
    output ready
  );
endinterface

// ===== design/wca_out_if.sv =====
`timescale 1ns / 1ps

interface wca_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] coverage;
  logic        covered;
  logic        run_start;
  logic [1:0]  error_code;

  modport source (
    output valid, result_kind, coverage, covered, run_start, error_code,
    input  ready
  );
  modport sink (
    input  valid, result_kind, coverage, covered, run_start, error_code,
    output ready
  );
endinterface

// ===== design/wca_cov_ram.sv =====
`timescale 1ns / 1ps

module wca_cov_ram (
  input  logic              clk_i,
  input  wca_pkg::ram_req_t req_i,
  output wca_pkg::cov_t     rd_data_o
);

  wca_pkg::cov_t mem [wca_pkg::MAX_LEN];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= mem[req_i.rd_addr];
    end
  end

endmodule

// ===== design/weighted_coverage_accumulator.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Word
// in_i     sink       operation, position, weight, cigar_code, cigar_length
// out_o    source     result_kind, coverage, covered, run_start, error_code
// cfg      write      chrom_length on cfg_data_i when cfg_we_i is high
//
// Begin, insertion, skip and ignored items end in the execute state, where a rejected
// item queues an error word. A match over n stored positions does one read-modify-write
// of the store per cycle, plus a write-back tail. A match that reports an error queues
// its error word only after its last write-back.
// After reset a clearing pass zeroes every entry of the store with in_i.ready low;
// configuration writes are taken during it.
// A result word waits in a holding register until the output register is free, and the
// input is held off while that holding register is full.

module weighted_coverage_accumulator (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [20:0]      cfg_data_i,
  wca_in_if.sink           in_i,
  wca_out_if.source        out_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_MATCH,
    ST_SCAN
  } state_e;

  state_e              state_q;
  wca_pkg::addr_t      clr_q;
  wca_pkg::lim_t       lim_q;

  wca_pkg::op_e        op_q;
  logic [19:0]         pos_q;
  logic [15:0]         wt_in_q;
  logic [3:0]          code_q;
  logic                len_nz_q;
  logic [31:0]         start_q;
  logic [32:0]         end_q;

  logic [31:0]         cur_pos_q;
  logic [15:0]         cur_wt_q;
  logic                prev_cov_q;

  wca_pkg::lim_t       p_q;
  wca_pkg::lim_t       stop_q;
  logic                rmw_q;
  wca_pkg::addr_t      rmw_addr_q;
  logic                errm_q;

  logic                pend_valid_q;
  logic                pend_kind_q;
  wca_pkg::cov_t       pend_cov_q;
  logic                pend_covered_q;
  logic                pend_run_q;
  wca_pkg::err_e       pend_err_q;

  logic                out_valid_q;
  logic                out_kind_q;
  wca_pkg::cov_t       out_cov_q;
  logic                out_covered_q;
  logic                out_run_q;
  wca_pkg::err_e       out_err_q;

  wca_pkg::ram_req_t   ram_req;
  wca_pkg::cov_t       rd_data;

  logic                in_fire;
  logic                move;
  logic                scan_ok;
  logic                rd_go;
  logic                err_w;
  logic                run_w;
  wca_pkg::lim_t       stop_w;
  logic [31:0]         sat_end;
  logic [32:0]         sum_w;
  wca_pkg::cov_t       sat_sum;
  logic                cov_w;
  logic                prev_w;

  assign in_i.ready = (state_q == ST_IDLE) && !pend_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign move       = pend_valid_q && (!out_valid_q || out_o.ready);

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.coverage    = out_cov_q;
  assign out_o.covered     = out_covered_q;
  assign out_o.run_start   = out_run_q;
  assign out_o.error_code  = out_err_q;

  always_comb begin
    scan_ok = 33'(pos_q) < 33'(lim_q);
    // A match only touches positions below both its end and the limit.
    stop_w  = (end_q < 33'(lim_q)) ? wca_pkg::LIM_W'(end_q) : lim_q;
    run_w   = 33'(start_q) < 33'(stop_w);
    err_w   = len_nz_q && (end_q > 33'(lim_q));
    sat_end = end_q[32] ? 32'hFFFF_FFFF : end_q[31:0];
    rd_go   = (p_q != stop_q);
    sum_w   = 33'(rd_data) + 33'({cur_wt_q, 1'b0});
    sat_sum = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
    cov_w   = (rd_data != '0);
    prev_w  = (pos_q == '0) ? 1'b0 : prev_cov_q;

    ram_req = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = clr_q;
      end
      ST_EXEC: begin
        ram_req.rd_en   = (op_q == wca_pkg::OP_SCAN) && scan_ok;
        ram_req.rd_addr = wca_pkg::ADDR_W'(pos_q);
      end
      ST_MATCH: begin
        ram_req.rd_en   = rd_go;
        ram_req.rd_addr = p_q[wca_pkg::ADDR_W-1:0];
        ram_req.wr_en   = rmw_q;
        ram_req.wr_addr = rmw_addr_q;
        ram_req.wr_data = sat_sum;
      end
      ST_SCAN: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = wca_pkg::ADDR_W'(pos_q);
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  wca_cov_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      lim_q          <= wca_pkg::LIM_W'(wca_pkg::LIM_RESET);
      op_q           <= wca_pkg::OP_NONE;
      pos_q          <= '0;
      wt_in_q        <= '0;
      code_q         <= '0;
      len_nz_q       <= 1'b0;
      start_q        <= '0;
      end_q          <= '0;
      cur_pos_q      <= '0;
      cur_wt_q       <= '0;
      prev_cov_q     <= 1'b0;
      p_q            <= '0;
      stop_q         <= '0;
      rmw_q          <= 1'b0;
      rmw_addr_q     <= '0;
      errm_q         <= 1'b0;
      pend_valid_q   <= 1'b0;
      pend_kind_q    <= wca_pkg::KIND_COV;
      pend_cov_q     <= '0;
      pend_covered_q <= 1'b0;
      pend_run_q     <= 1'b0;
      pend_err_q     <= wca_pkg::ERR_NONE;
      out_valid_q    <= 1'b0;
      out_kind_q     <= wca_pkg::KIND_COV;
      out_cov_q      <= '0;
      out_covered_q  <= 1'b0;
      out_run_q      <= 1'b0;
      out_err_q      <= wca_pkg::ERR_NONE;
    end else begin
      if (cfg_we_i) begin
        lim_q <= (33'(cfg_data_i) > 33'(wca_pkg::MAX_LEN)) ?
                 wca_pkg::LIM_W'(wca_pkg::MAX_LEN) : wca_pkg::LIM_W'(cfg_data_i);
      end

      if (move) begin
        out_valid_q   <= 1'b1;
        out_kind_q    <= pend_kind_q;
        out_cov_q     <= pend_cov_q;
        out_covered_q <= pend_covered_q;
        out_run_q     <= pend_run_q;
        out_err_q     <= pend_err_q;
        pend_valid_q  <= 1'b0;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == wca_pkg::ADDR_W'(wca_pkg::MAX_LEN - 1)) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_fire) begin
            op_q     <= wca_pkg::op_e'(in_i.operation);
            pos_q    <= in_i.position;
            wt_in_q  <= in_i.weight;
            code_q   <= in_i.cigar_code;
            len_nz_q <= (in_i.cigar_length != '0);
            start_q  <= cur_pos_q;
            end_q    <= 33'(cur_pos_q) + 33'(in_i.cigar_length);
            state_q  <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          unique case (op_q)
            wca_pkg::OP_BEGIN: begin
              cur_pos_q <= 32'(pos_q);
              cur_wt_q  <= wt_in_q;
              state_q   <= ST_IDLE;
            end
            wca_pkg::OP_CIGAR: begin
              unique case (code_q) inside
                wca_pkg::CIGAR_MATCH: begin
                  cur_pos_q <= sat_end;
                  errm_q    <= err_w;
                  stop_q    <= stop_w;
                  // With nothing to cover the pointer starts at the stop mark.
                  p_q       <= run_w ? wca_pkg::LIM_W'(start_q) : stop_w;
                  rmw_q     <= 1'b0;
                  state_q   <= ST_MATCH;
                end
                wca_pkg::CIGAR_INS, wca_pkg::CIGAR_SKIP: begin
                  cur_pos_q <= sat_end;
                  state_q   <= ST_IDLE;
                end
                default: begin
                  pend_valid_q   <= 1'b1;
                  pend_kind_q    <= wca_pkg::KIND_ERR;
                  pend_cov_q     <= '0;
                  pend_covered_q <= 1'b0;
                  pend_run_q     <= 1'b0;
                  pend_err_q     <= wca_pkg::ERR_CODE;
                  state_q        <= ST_IDLE;
                end
              endcase
            end
            wca_pkg::OP_SCAN: begin
              if (scan_ok) begin
                state_q <= ST_SCAN;
              end else begin
                pend_valid_q   <= 1'b1;
                pend_kind_q    <= wca_pkg::KIND_ERR;
                pend_cov_q     <= '0;
                pend_covered_q <= 1'b0;
                pend_run_q     <= 1'b0;
                pend_err_q     <= wca_pkg::ERR_RANGE;
                state_q        <= ST_IDLE;
              end
            end
            wca_pkg::OP_NONE: begin
              state_q <= ST_IDLE;
            end
          endcase
        end

        ST_MATCH: begin
          // Read one entry a cycle; its sum is written back in the next cycle,
          // always to an address behind the one being read.
          if (rd_go) begin
            p_q        <= p_q + 1'b1;
            rmw_q      <= 1'b1;
            rmw_addr_q <= p_q[wca_pkg::ADDR_W-1:0];
          end else begin
            rmw_q <= 1'b0;
          end
          if (!rd_go && !rmw_q) begin
            state_q <= ST_IDLE;
            if (errm_q) begin
              pend_valid_q   <= 1'b1;
              pend_kind_q    <= wca_pkg::KIND_ERR;
              pend_cov_q     <= '0;
              pend_covered_q <= 1'b0;
              pend_run_q     <= 1'b0;
              pend_err_q     <= wca_pkg::ERR_RANGE;
            end
          end
        end

        ST_SCAN: begin
          prev_cov_q     <= cov_w;
          pend_valid_q   <= 1'b1;
          pend_kind_q    <= wca_pkg::KIND_COV;
          pend_cov_q     <= rd_data;
          pend_covered_q <= cov_w;
          pend_run_q     <= cov_w && !prev_w;
          pend_err_q     <= wca_pkg::ERR_NONE;
          state_q        <= ST_IDLE;
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/wca_checker.sv =====
`timescale 1ns / 1ps

module wca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        result_kind_i,
  input logic [31:0] coverage_i,
  input logic        covered_i,
  input logic        run_start_i,
  input logic [1:0]  error_code_i
);

  // A waiting result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(coverage_i) &&
      $stable(result_kind_i) && $stable(error_code_i))
    else $error("result word changed while stalled");

  // Error reports carry a code and nothing else.
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == wca_pkg::KIND_ERR) |->
      (error_code_i != wca_pkg::ERR_NONE) && (coverage_i == '0) &&
      !covered_i && !run_start_i)
    else $error("malformed error report");

  // Scan results flag coverage consistently and carry no error code.
  a_scan_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == wca_pkg::KIND_COV) |->
      (error_code_i == wca_pkg::ERR_NONE) && (covered_i == (coverage_i != '0)) &&
      (!run_start_i || covered_i))
    else $error("malformed scan result");

  // Items are worked one at a time, so an accepted word blocks the next cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted on consecutive cycles");

endmodule

bind weighted_coverage_accumulator wca_checker u_wca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .result_kind_i (out_o.result_kind),
  .coverage_i    (out_o.coverage),
  .covered_i     (out_o.covered),
  .run_start_i   (out_o.run_start),
  .error_code_i  (out_o.error_code)
);
